/* src/ramped_wind_power_law_shear_unit_defines.svh */
// assertion macros for the ramped wind shear unit
// used by the top level; relies on i_clk and i_rst_n being in scope
`ifndef RAMPED_WIND_POWER_LAW_SHEAR_UNIT_DEFINES_SVH
`define RAMPED_WIND_POWER_LAW_SHEAR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked outside reset
`define RWPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked during reset as well
`define RWPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define RWPS_ASSERT(lbl, prop, msg)
`define RWPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* src/rwps_pkg.sv */
// shared constants, types and elaboration-time functions for the wind shear unit
// no dependencies
package rwps_pkg;

    localparam int POS_W   = 32;
    localparam int VEL_W   = 16;
    localparam int LOG_W   = 21;
    localparam int FRAC_W  = 16;
    localparam int MANT_W  = 31;
    localparam int DIV_STEPS = 16;
    localparam int EXP_STEPS = 16;
    localparam int LOG_STEPS = 16;
    localparam int IDX_W   = 8;
    localparam int CFG_W   = 48;

    typedef enum logic [IDX_W-1:0] {
        REG_START_VEL  = 8'd0,
        REG_STOP_VEL   = 8'd1,
        REG_RAMP_BEGIN = 8'd2,
        REG_RAMP_END   = 8'd3,
        REG_SHEAR_EXP  = 8'd4,
        REG_BASE_HGT   = 8'd5,
        REG_HGT_CAP    = 8'd6,
        REG_DOWN_DIR   = 8'd7
    } t_reg_idx;

    localparam logic [47:0] RST_VEL      = 48'd0;
    localparam logic [31:0] RST_TIME     = 32'd0;
    localparam logic [15:0] RST_SHEAR    = 16'd2341;
    localparam logic [31:0] RST_BASE_HGT = 32'd655360;
    localparam logic [30:0] RST_HGT_CAP  = 31'd6553600;
    localparam logic [47:0] RST_DOWN_DIR = 48'd211106232532992;

    typedef struct packed {
        logic early;
        logic empty;
        logic full;
    } t_ramp_flags;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] rem;
        res  = '0;
        bitv = 64'h4000_0000_0000_0000;
        rem  = x;
        for (int i = 0; i < 32; i++) begin
            if (bitv > rem) bitv = bitv >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bitv != 64'd0) begin
                if (rem >= res + bitv) begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // 2^(2^-k) in Q1.30, each the truncated root of the one before
    function automatic logic [MANT_W-1:0] exp_root(input int k);
        logic [63:0] r;
        r = 64'd2 << 30;
        for (int j = 1; j <= EXP_STEPS; j++) begin
            if (j <= k) r = isqrt64(r << 30);
        end
        return r[MANT_W-1:0];
    endfunction

endpackage

/* src/ramped_wind_power_law_shear_unit.sv */
// top level of the ramped wind unit with power-law height shear
// depends on rwps_pkg, rwps_div, rwps_log2, rwps_exp2 and the assertion header

// A query (position and time) enters on the input request channel and passes
// through 40 register stages before its wind vector is offered on the output
// channel. A new query is taken every cycle unless the output stalls, so
// throughput is one per clock. The pipeline depth is set by
// the chain from the height through the 17-stage log2 unit (normalise plus
// sixteen squarings), the exponent multiply and the 16-stage exp2 unit
// (one constant root factor per fraction bit). The ramp fraction comes from
// a 16-stage restoring divider that runs alongside. The whole pipeline moves
// together: when the output register holds an untaken result, every stage
// and the input stall. Configuration registers are written through their
// own port, which is always ready; write them only while the block is idle.
// Unknown register indexes are ignored.
`include "ramped_wind_power_law_shear_unit_defines.svh"

module ramped_wind_power_law_shear_unit
    import rwps_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // query request
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    input  logic [31:0]             i_query_time,
    // wind result
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [VEL_W-1:0] o_wind_x,
    output logic signed [VEL_W-1:0] o_wind_y,
    output logic signed [VEL_W-1:0] o_wind_z,
    output logic                    o_below_ground,
    // configuration writes
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    // stage numbers along the pipe
    localparam int S_DIV  = 2 + DIV_STEPS;       // fraction ready
    localparam int S_BLND = S_DIV + 1;           // blend products
    localparam int S_BASE = S_DIV + 2;           // base wind
    localparam int S_LOG  = 3 + LOG_STEPS + 1;   // both logs ready
    localparam int S_QP   = S_LOG + 1;           // exponent product
    localparam int S_Q    = S_QP + 1;            // n and fraction
    localparam int S_EXP  = S_Q + EXP_STEPS;     // mantissa ready
    localparam int S_PROD = S_EXP + 1;           // scaled products
    localparam int LAT    = S_PROD + 1;          // output register

    // configuration registers
    logic [47:0] r_start_vel;
    logic [47:0] r_stop_vel;
    logic [31:0] r_ramp_begin;
    logic [31:0] r_ramp_end;
    logic [15:0] r_shear_exp;
    logic [31:0] r_base_hgt;
    logic [30:0] r_hgt_cap;
    logic [47:0] r_down_dir;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_vel  <= RST_VEL;
            r_stop_vel   <= RST_VEL;
            r_ramp_begin <= RST_TIME;
            r_ramp_end   <= RST_TIME;
            r_shear_exp  <= RST_SHEAR;
            r_base_hgt   <= RST_BASE_HGT;
            r_hgt_cap    <= RST_HGT_CAP;
            r_down_dir   <= RST_DOWN_DIR;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_START_VEL:  r_start_vel  <= i_cfg_data;
                REG_STOP_VEL:   r_stop_vel   <= i_cfg_data;
                REG_RAMP_BEGIN: r_ramp_begin <= i_cfg_data[31:0];
                REG_RAMP_END:   r_ramp_end   <= i_cfg_data[31:0];
                REG_SHEAR_EXP:  r_shear_exp  <= i_cfg_data[15:0];
                REG_BASE_HGT:   r_base_hgt   <= i_cfg_data[31:0];
                REG_HGT_CAP:    r_hgt_cap    <= i_cfg_data[30:0];
                REG_DOWN_DIR:   r_down_dir   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: everything moves unless the output is held
    logic w_en;
    logic [LAT:1] r_vld;

    assign w_en        = !r_vld[LAT] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-1:1], i_in_valid};
        end
    end

    // stage 1: capture the query
    logic signed [POS_W-1:0] r_pos [0:2];
    logic [31:0]             r_t;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pos[0] <= i_pos_x;
            r_pos[1] <= i_pos_y;
            r_pos[2] <= i_pos_z;
            r_t      <= i_query_time;
        end
    end

    // stage 2: dot product terms and ramp timing
    logic signed [47:0] r_dp [0:2];
    logic [31:0]        r_dt;
    logic [31:0]        r_span;
    t_ramp_flags        r_fl [2:S_BASE];
    logic [31:0]        w_dt;
    logic [31:0]        w_span;

    assign w_dt   = r_t - r_ramp_begin;
    assign w_span = r_ramp_end - r_ramp_begin;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_dp[i] <= 48'($signed(r_down_dir[16*i +: 16])) * 48'(r_pos[i]);
            end
            r_dt          <= w_dt;
            r_span        <= w_span;
            r_fl[2].early  <= r_t < r_ramp_begin;
            r_fl[2].empty  <= r_ramp_end <= r_ramp_begin;
            r_fl[2].full   <= w_dt >= w_span;
            for (int s = 3; s <= S_BASE; s++) r_fl[s] <= r_fl[s-1];
        end
    end

    // stage 3: height along up, capped; ground test
    logic signed [50:0] w_negdot;
    logic signed [50:0] w_hraw;
    logic signed [50:0] w_hcap;
    logic [30:0]        r_h;
    logic               r_below [3:S_PROD];

    always_comb begin
        w_negdot = -(51'(r_dp[0]) + 51'(r_dp[1]) + 51'(r_dp[2]));
        w_hraw   = w_negdot >>> 14;
        w_hcap   = (w_hraw > $signed({20'd0, r_hgt_cap})) ? $signed({20'd0, r_hgt_cap})
                                                          : w_hraw;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h        <= w_hcap[30:0];
            r_below[3] <= w_hcap <= 51'sd0;
            for (int s = 4; s <= S_PROD; s++) r_below[s] <= r_below[s-1];
        end
    end

    // ramp fraction
    logic [DIV_STEPS-1:0] w_quo;

    rwps_div u_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_dt   (r_dt),
        .i_span (r_span),
        .o_quo  (w_quo)
    );

    // blend: start*(1-f) + stop*f with round half up
    logic [16:0]        w_wf;
    logic [16:0]        w_wa;
    logic signed [33:0] r_pa [0:2];
    logic signed [33:0] r_pb [0:2];

    assign w_wf = r_fl[S_DIV].full ? 17'h10000 : {1'b0, w_quo};
    assign w_wa = 17'h10000 - w_wf;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_pa[i] <= 34'($signed(r_start_vel[16*i +: 16])) * $signed({17'd0, w_wa});
                r_pb[i] <= 34'($signed(r_stop_vel[16*i +: 16])) * $signed({17'd0, w_wf});
            end
        end
    end

    // three lanes of base wind carried as one packed word
    logic [3*VEL_W-1:0] r_bw [S_BASE:S_EXP];
    logic [3*VEL_W-1:0] w_bw;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_fl[S_BLND].early) begin
                w_bw[16*i +: 16] = r_start_vel[16*i +: 16];
            end else if (r_fl[S_BLND].empty) begin
                w_bw[16*i +: 16] = r_stop_vel[16*i +: 16];
            end else begin
                w_bw[16*i +: 16] = 16'((35'(r_pa[i]) + 35'(r_pb[i]) + 35'sd32768) >>> 16);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bw[S_BASE] <= w_bw;
            for (int s = S_BASE + 1; s <= S_EXP; s++) r_bw[s] <= r_bw[s-1];
        end
    end

    // logs of the height and of the reference height (zero taken as one)
    logic [LOG_W-1:0] w_logh;
    logic [LOG_W-1:0] w_logr;
    logic [31:0]      w_ref;

    assign w_ref = (r_base_hgt == 32'd0) ? 32'd1 : r_base_hgt;

    rwps_log2 u_log_h (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   ({1'b0, r_h}),
        .o_log (w_logh)
    );

    rwps_log2 u_log_r (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (w_ref),
        .o_log (w_logr)
    );

    // exponent product, then split into integer and fraction
    logic signed [21:0] w_diff;
    logic signed [38:0] r_qp;
    logic signed [8:0]  r_n [S_Q:S_EXP];
    logic [FRAC_W-1:0]  r_qfrac;

    assign w_diff = $signed({1'b0, w_logh}) - $signed({1'b0, w_logr});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qp    <= 39'(w_diff) * $signed({23'd0, r_shear_exp});
            r_n[S_Q] <= r_qp[38:30];
            r_qfrac <= r_qp[29:14];
            for (int s = S_Q + 1; s <= S_EXP; s++) r_n[s] <= r_n[s-1];
        end
    end

    logic [MANT_W-1:0] w_mant;

    rwps_exp2 u_exp (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_frac (r_qfrac),
        .o_mant (w_mant)
    );

    // scaled products and shift amount
    logic signed [47:0] r_prod [0:2];
    logic               r_vz   [0:2];
    logic               r_neg  [0:2];
    logic signed [9:0]  r_sh;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= 48'($signed(r_bw[S_EXP][16*i +: 16])) * $signed({17'd0, w_mant});
                r_vz[i]   <= r_bw[S_EXP][16*i +: 16] == 16'd0;
                r_neg[i]  <= r_bw[S_EXP][16*i + 15];
            end
            r_sh <= 10'sd30 - 10'(r_n[S_EXP]);
        end
    end

    // round half up, shift down, saturate
    function automatic logic [VEL_W-1:0] scale_lane(
        input logic signed [47:0] prod,
        input logic               vz,
        input logic               neg,
        input logic signed [9:0]  sh
    );
        logic signed [48:0] rnd;
        logic signed [48:0] res;
        logic [5:0]         amt;
        amt = sh[5:0];
        rnd = 49'(prod) + (49'sd1 <<< (amt - 6'd1));
        res = rnd >>> amt;
        if (vz || sh >= 10'sd48) begin
            scale_lane = '0;
        end else if (sh <= 10'sd0) begin
            scale_lane = neg ? 16'h8000 : 16'h7fff;
        end else if (res > 49'sd32767) begin
            scale_lane = 16'h7fff;
        end else if (res < -49'sd32768) begin
            scale_lane = 16'h8000;
        end else begin
            scale_lane = res[15:0];
        end
    endfunction

    logic [VEL_W-1:0] r_wind [0:2];
    logic             r_below_out;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_wind[i] <= r_below[S_PROD] ? '0
                             : scale_lane(r_prod[i], r_vz[i], r_neg[i], r_sh);
            end
            r_below_out <= r_below[S_PROD];
        end
    end

    assign o_wind_x       = $signed(r_wind[0]);
    assign o_wind_y       = $signed(r_wind[1]);
    assign o_wind_z       = $signed(r_wind[2]);
    assign o_below_ground = r_below_out;

    // a ground result carries no wind
    `RWPS_ASSERT(a_ground_zero, o_out_valid && o_below_ground |-> o_wind_x == 16'sd0 && o_wind_y == 16'sd0 && o_wind_z == 16'sd0, "ground result with non-zero wind")
    // reset empties the pipe
    `RWPS_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_out_valid && r_vld == '0, "pipe not empty after reset")
    // a stall freezes the occupancy of every stage
    `RWPS_ASSERT(a_stall_hold, !w_en |=> $stable(r_vld), "pipe moved during stall")
    // config port never back-pressures
    `RWPS_ASSERT(a_cfg_ready, o_cfg_ready, "config port not ready")

endmodule

/* src/rwps_div.sv */
// restoring divider for the ramp blend fraction, one quotient bit per stage
// depends on rwps_pkg
module rwps_div
    import rwps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [31:0]          i_dt,
    input  logic [31:0]          i_span,
    output logic [DIV_STEPS-1:0] o_quo
);

    logic [31:0]          r_rem  [1:DIV_STEPS];
    logic [31:0]          r_span [1:DIV_STEPS];
    logic [DIV_STEPS-1:0] r_quo  [1:DIV_STEPS];

    for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_stage
        logic [31:0]          prem;
        logic [31:0]          pspan;
        logic [DIV_STEPS-1:0] pquo;
        logic [32:0]          shl;
        logic                 ge;
        if (j == 1) begin : g_first
            assign prem  = i_dt;
            assign pspan = i_span;
            assign pquo  = '0;
        end else begin : g_next
            assign prem  = r_rem[j-1];
            assign pspan = r_span[j-1];
            assign pquo  = r_quo[j-1];
        end
        assign shl = {prem, 1'b0};
        assign ge  = shl >= {1'b0, pspan};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= ge ? 32'(shl - {1'b0, pspan}) : shl[31:0];
                r_span[j] <= pspan;
                r_quo[j]  <= {pquo[DIV_STEPS-2:0], ge};
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS];

endmodule

/* src/rwps_log2.sv */
// pipelined log2 in q.16: normalise stage then one squaring per fraction bit
// depends on rwps_pkg
module rwps_log2
    import rwps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [31:0]      i_x,
    output logic [LOG_W-1:0] o_log
);

    logic [4:0]          r_k   [0:LOG_STEPS];
    logic [31:0]         r_y   [0:LOG_STEPS];
    logic [FRAC_W-1:0]   r_frc [0:LOG_STEPS];
    logic [4:0]          w_k;

    always_comb begin
        w_k = '0;
        for (int i = 0; i < 32; i++) begin
            if (i_x[i]) w_k = 5'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k[0]   <= w_k;
            r_y[0]   <= i_x << (5'd31 - w_k);
            r_frc[0] <= '0;
        end
    end

    for (genvar j = 1; j <= LOG_STEPS; j++) begin : g_sq
        logic [63:0] sq;
        logic        ov;
        assign sq = 64'(r_y[j-1]) * 64'(r_y[j-1]);
        assign ov = sq[63];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_k[j]   <= r_k[j-1];
                r_y[j]   <= ov ? sq[63:32] : sq[62:31];
                r_frc[j] <= {r_frc[j-1][FRAC_W-2:0], ov};
            end
        end
    end

    assign o_log = {r_k[LOG_STEPS], r_frc[LOG_STEPS]};

endmodule

/* src/rwps_exp2.sv */
// pipelined 2^f for a 16-bit fraction, one constant root factor per stage, q1.30
// depends on rwps_pkg
module rwps_exp2
    import rwps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [FRAC_W-1:0] i_frac,
    output logic [MANT_W-1:0] o_mant
);

    logic [MANT_W-1:0] r_m   [1:EXP_STEPS];
    logic [FRAC_W-1:0] r_frc [1:EXP_STEPS];

    for (genvar j = 1; j <= EXP_STEPS; j++) begin : g_mul
        localparam logic [MANT_W-1:0] ROOT = exp_root(j);
        logic [MANT_W-1:0] pm;
        logic [FRAC_W-1:0] pf;
        logic [61:0]       prod;
        if (j == 1) begin : g_first
            assign pm = MANT_W'(1) << 30;
            assign pf = i_frac;
        end else begin : g_next
            assign pm = r_m[j-1];
            assign pf = r_frc[j-1];
        end
        assign prod = 62'(pm) * 62'(ROOT);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[j]   <= pf[FRAC_W-j] ? prod[60:30] : pm;
                r_frc[j] <= pf;
            end
        end
    end

    assign o_mant = r_m[EXP_STEPS];

endmodule

/* tb/wind_shear_checker.sv */
// checker for the ramped wind shear unit: mirrors the register writes, predicts
// each wind vector from the accepted queries and compares the results in order
// depends on rwps_pkg
module wind_shear_checker
    import rwps_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    input  logic [31:0]             i_query_time,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic signed [VEL_W-1:0] i_wind_x,
    input  logic signed [VEL_W-1:0] i_wind_y,
    input  logic signed [VEL_W-1:0] i_wind_z,
    input  logic                    i_below_ground,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    output int                      o_pending,
    output int                      o_errors
);

    typedef struct packed {
        logic [15:0] wx;
        logic [15:0] wy;
        logic [15:0] wz;
        logic        below;
    } t_wind;

    logic [47:0] start_vel, stop_vel, down_dir;
    logic [31:0] ramp_begin, ramp_end, base_hgt;
    logic [15:0] shear_exp;
    logic [30:0] hgt_cap;

    t_wind wind_expected[$];
    int    err_count = 0;

    assign o_pending = wind_expected.size();
    assign o_errors  = err_count;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    function automatic longint lane(input logic [47:0] packed_v, input int idx);
        logic signed [15:0] s;
        s = packed_v[16*idx +: 16];
        return longint'(s);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res, b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // log2 in Q.16, fraction by repeated squaring of the mantissa
    function automatic longint log2_fix(input longint unsigned x);
        int k;
        longint unsigned y, frac;
        k = 0;
        frac = 0;
        while (k < 31 && (x >> (k + 1)) != 0) k++;
        y = x << (31 - k);
        for (int i = 0; i < 16; i++) begin
            y = (y * y) >> 31;
            frac = frac << 1;
            if (y >= (64'd2 << 31)) begin
                y = y >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(k) << 16) | longint'(frac);
    endfunction

    // 2^(f/2^16) in Q1.30 from successive truncated roots of two
    function automatic longint exp2_mant(input logic [15:0] f);
        longint unsigned root, m;
        root = 64'd2 << 30;
        m = 64'd1 << 30;
        for (int k = 1; k <= 16; k++) begin
            root = int_sqrt(root << 30);
            if (f[16-k]) m = (m * root) >> 30;
        end
        return longint'(m);
    endfunction

    function automatic logic [15:0] clip16(input longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic t_wind predict_wind(input logic [31:0] px, input logic [31:0] py,
                                           input logic [31:0] pz, input logic [31:0] t);
        longint base[3], pos[3], dot, h, q, n, sh, m, f, v, r, refh;
        longint unsigned dt, span;
        t_wind w;
        pos[0] = longint'($signed(px));
        pos[1] = longint'($signed(py));
        pos[2] = longint'($signed(pz));
        for (int i = 0; i < 3; i++) begin
            if (t < ramp_begin) begin
                base[i] = lane(start_vel, i);
            end else if (ramp_end <= ramp_begin) begin
                base[i] = lane(stop_vel, i);
            end else begin
                dt = 64'(t - ramp_begin);
                span = 64'(ramp_end - ramp_begin);
                f = longint'((dt << 16) / span);
                if (f > 65536) f = 65536;
                base[i] = (lane(start_vel, i) * (65536 - f) + lane(stop_vel, i) * f
                           + 32768) >>> 16;
            end
        end
        dot = 0;
        for (int i = 0; i < 3; i++) dot += lane(down_dir, i) * pos[i];
        h = (-dot) >>> 14;
        if (h > longint'(hgt_cap)) h = longint'(hgt_cap);
        w = '0;
        if (h <= 0) begin
            w.below = 1'b1;
            return w;
        end
        refh = (base_hgt == 0) ? 1 : longint'(base_hgt);
        q = ((log2_fix(h) - log2_fix(refh)) * longint'(shear_exp)) >>> 14;
        n = q >>> 16;
        m = exp2_mant(q[15:0]);
        sh = 30 - n;
        for (int i = 0; i < 3; i++) begin
            v = base[i];
            if (v == 0 || sh >= 48) r = 0;
            else if (sh <= 0) r = (v > 0) ? 32767 : -32768;
            else r = (v * m + (longint'(1) << (sh - 1))) >>> sh;
            if (i == 0) w.wx = clip16(r);
            else if (i == 1) w.wy = clip16(r);
            else w.wz = clip16(r);
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_wind got, want;
        if (!i_rst_n) begin
            start_vel  <= RST_VEL;
            stop_vel   <= RST_VEL;
            ramp_begin <= RST_TIME;
            ramp_end   <= RST_TIME;
            shear_exp  <= RST_SHEAR;
            base_hgt   <= RST_BASE_HGT;
            hgt_cap    <= RST_HGT_CAP;
            down_dir   <= RST_DOWN_DIR;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_START_VEL:  start_vel  <= i_cfg_data;
                    REG_STOP_VEL:   stop_vel   <= i_cfg_data;
                    REG_RAMP_BEGIN: ramp_begin <= i_cfg_data[31:0];
                    REG_RAMP_END:   ramp_end   <= i_cfg_data[31:0];
                    REG_SHEAR_EXP:  shear_exp  <= i_cfg_data[15:0];
                    REG_BASE_HGT:   base_hgt   <= i_cfg_data[31:0];
                    REG_HGT_CAP:    hgt_cap    <= i_cfg_data[30:0];
                    REG_DOWN_DIR:   down_dir   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                got = {i_wind_x, i_wind_y, i_wind_z, i_below_ground};
                if (wind_expected.size() == 0) begin
                    report("unexpected result", longint'(got), 0);
                end else begin
                    want = wind_expected.pop_front();
                    if (got.wx != want.wx) report("wind_x", got.wx, want.wx);
                    if (got.wy != want.wy) report("wind_y", got.wy, want.wy);
                    if (got.wz != want.wz) report("wind_z", got.wz, want.wz);
                    if (got.below != want.below) report("below_ground", got.below, want.below);
                end
            end
            if (i_in_valid && i_in_ready)
                wind_expected.push_back(predict_wind(i_pos_x, i_pos_y, i_pos_z, i_query_time));
        end
    end

endmodule

/* tb/tb_top.sv */
// top of the wind shear testbench: clock, reset, query and register stimulus,
// random output stalls and the verdict; checking lives in wind_shear_checker
// depends on rwps_pkg, ramped_wind_power_law_shear_unit and wind_shear_checker
module tb_top;
    import rwps_pkg::*;

    localparam logic [IDX_W-1:0] UNUSED_IDX = 8'd200;
    localparam logic [15:0]      ONE_Q14    = 16'h4000;
    localparam logic [15:0]      MINUS_Q14  = 16'hC000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic signed [POS_W-1:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic [31:0]             i_query_time = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [VEL_W-1:0] o_wind_x, o_wind_y, o_wind_z;
    logic                    o_below_ground;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;
    int                      pending, errors;
    bit                      no_idle = 1'b0;

    // shadow of the ramp times, used to aim query times at the ramp
    logic [31:0] cur_begin = 0, cur_end = 0;

    always #10 i_clk = ~i_clk;

    ramped_wind_power_law_shear_unit dut (.*);

    wind_shear_checker chk (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_in_ready(o_in_ready),
        .i_pos_x, .i_pos_y, .i_pos_z, .i_query_time,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_wind_x(o_wind_x), .i_wind_y(o_wind_y), .i_wind_z(o_wind_z),
        .i_below_ground(o_below_ground),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_pending(pending), .o_errors(errors)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if (no_idle) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(8, 30);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // receiver stalls on the falling edge, same gap shape as the sender
    always @(negedge i_clk) begin
        int stall;
        stall = 0;
        if (i_rst_n && !no_idle && $urandom_range(0, 3) == 0) begin
            i_out_ready = 1'b0;
            stall = gap_len();
            repeat (stall) @(negedge i_clk);
        end
        i_out_ready = 1'b1;
    end

    // wait for every result, then let the pipeline drain before a register write
    task automatic wait_idle();
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        if (idx == REG_RAMP_BEGIN) cur_begin = val[31:0];
        if (idx == REG_RAMP_END) cur_end = val[31:0];
    endtask

    // one query request, held until taken
    task automatic send_query(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz, input logic [31:0] t);
        repeat (gap_len()) @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_pos_x      = px;
        i_pos_y      = py;
        i_pos_z      = pz;
        i_query_time = t;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    function automatic logic [15:0] rand_vel();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_time();
        case ($urandom_range(0, 3))
            0: return $urandom;
            default: return $urandom_range(0, 32'h0064_0000);
        endcase
    endfunction

    // vertical down, vertical up, tilted downward or a fully random direction, evenly mixed
    function automatic logic [47:0] rand_down();
        case ($urandom_range(0, 3))
            0: return {MINUS_Q14, 16'h0000, 16'h0000};
            1: return {16'($urandom), 16'($urandom), 16'($urandom)};
            2: return {ONE_Q14, 16'h0000, 16'h0000};
            default: return {16'($urandom_range(16'hC000, 16'hE000)),
                             16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000))};
        endcase
    endfunction

    task automatic random_config(input int extreme);
        logic [31:0] b;
        write_reg(REG_START_VEL, {rand_vel(), rand_vel(), rand_vel()});
        write_reg(REG_STOP_VEL, {rand_vel(), rand_vel(), rand_vel()});
        b = extreme ? 32'hFFFF_FFFF : rand_time();
        write_reg(REG_RAMP_BEGIN, 48'(b));
        case ($urandom_range(0, 4))
            0: write_reg(REG_RAMP_END, 48'(b));                          // empty ramp
            1: write_reg(REG_RAMP_END, 48'($urandom));
            default: write_reg(REG_RAMP_END, 48'(b + $urandom_range(1, 32'h0020_0000)));
        endcase
        write_reg(REG_SHEAR_EXP, extreme ? 48'hFFFF : 48'($urandom_range(0, 16'hFFFF)));
        case ($urandom_range(0, 5))
            0: write_reg(REG_BASE_HGT, 48'd0);
            1: write_reg(REG_BASE_HGT, 48'h0000_FFFF_FFFF);
            2: write_reg(REG_BASE_HGT, 48'd1);
            default: write_reg(REG_BASE_HGT, 48'($urandom_range(32'h0001_0000, 32'h0064_0000)));
        endcase
        write_reg(REG_HGT_CAP, extreme ? 48'h7FFF_FFFF :
                  ($urandom_range(0, 3) == 0 ? 48'($urandom) :
                   48'($urandom_range(32'h0001_0000, 32'h0100_0000))));
        write_reg(REG_DOWN_DIR, rand_down());
        // stray index must be ignored
        if ($urandom_range(0, 1)) write_reg(UNUSED_IDX, {$urandom, 16'($urandom)});
    endtask

    task automatic random_query();
        logic [31:0] px, py, pz, t;
        if ($urandom_range(0, 4) == 0) begin
            // noise over the full field ranges
            px = $urandom;
            py = $urandom;
            pz = $urandom;
        end else begin
            px = $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000;
            py = $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000;
            pz = $urandom_range(0, 32'h0130_0000) - 32'h0010_0000;
        end
        case ($urandom_range(0, 4))
            0: t = $urandom;
            1: t = cur_begin - $urandom_range(0, 255);
            2: t = cur_end + $urandom_range(0, 255);
            default: t = cur_begin + $urandom_range(0, 32'h0020_0000);
        endcase
        send_query(px, py, pz, t);
    endtask

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset registers: zero velocity, so only the ground flag moves
        send_query(32'd0, 32'd0, 32'h0014_0000, 32'd0);
        send_query(32'd0, 32'd0, 32'hFFF0_0000, 32'd5);
        send_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        wait_idle();

        // directed ramp and shear corners
        write_reg(REG_START_VEL, {16'h0001, 16'h8000, 16'h7FFF});
        write_reg(REG_STOP_VEL, {16'hFFFF, 16'h7FFF, 16'h8000});
        write_reg(REG_RAMP_BEGIN, 48'h000A_0000);
        write_reg(REG_RAMP_END, 48'h0014_0000);
        send_query(32'd0, 32'd0, 32'h000A_0000, 32'h0009_FFFF);    // before ramp
        send_query(32'd0, 32'd0, 32'h000A_0000, 32'h000A_0000);    // ramp start
        send_query(32'd0, 32'd0, 32'h000A_0000, 32'h000F_0000);    // half way
        send_query(32'd0, 32'd0, 32'h000A_0000, 32'h0014_0000);    // ramp end
        send_query(32'd0, 32'd0, 32'h000A_0000, 32'hFFFF_FFFF);    // clamped fraction
        send_query(32'd0, 32'd0, 32'd0, 32'd0);                    // ground level
        send_query(32'd0, 32'd0, 32'h8000_0000, 32'd0);            // far below
        send_query(32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0);            // above the cap
        send_query(32'd0, 32'd0, 32'd1, 32'd0);                    // tiny height
        wait_idle();
        write_reg(REG_RAMP_END, 48'h0005_0000);                    // empty ramp
        write_reg(REG_SHEAR_EXP, 48'hFFFF);
        write_reg(REG_BASE_HGT, 48'd0);                            // zero reference
        write_reg(REG_HGT_CAP, 48'h7FFF_FFFF);
        send_query(32'd0, 32'd0, 32'h0001_0000, 32'h000A_0000);
        send_query(32'd0, 32'd0, 32'h7FFF_FFFF, 32'h0000_0000);    // saturating scale
        send_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0010_0000);
        wait_idle();
        write_reg(REG_DOWN_DIR, {16'h8000, 16'h7FFF, 16'h8000});
        write_reg(REG_BASE_HGT, 48'h0000_FFFF_FFFF);
        send_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0);
        send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
        send_query(32'h1234_5678, 32'h8765_4321, 32'hA5A5_5A5A, 32'd0);
        wait_idle();

        // random phases, some with extreme registers and some with no idling
        for (int phase = 0; phase < 10; phase++) begin
            no_idle = (phase % 4 == 3);
            random_config(phase == 2 || phase == 7);
            repeat (110) random_query();
            wait_idle();
        end
        no_idle = 1'b0;

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
